>>> rtl/aob_pkg.sv
// ----------------------------------------------------------------------------
// aob_pkg
// Shared types and constants for the alpha-over opacity blend pipeline.
// ----------------------------------------------------------------------------
package aob_pkg;

    localparam int FRAC_BITS = 16;
    localparam int OP_W      = FRAC_BITS + 1;
    localparam int Y_W       = FRAC_BITS + 8;
    localparam int OUTA_W    = FRAC_BITS + 2;
    localparam int NUM_W     = FRAC_BITS + 10;
    localparam int D_W       = OUTA_W + 1;
    localparam int Q_W       = 9;
    localparam int DIV_LAT   = Q_W;

    localparam logic [OP_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [OP_W-1:0] COPY_THRESH =
        OP_W'((64'd999 * (64'd1 << FRAC_BITS) + 64'd999) / 64'd1000);

    // floor(2^32 / 255), underestimates x/255 by at most one
    localparam int          RECIP_SH  = 32;
    localparam logic [31:0] RECIP_255 = 32'h0101_0101;

    typedef struct packed {
        logic [7:0] src_r;
        logic [7:0] src_g;
        logic [7:0] src_b;
        logic [7:0] src_a;
        logic [7:0] dst_r;
        logic [7:0] dst_g;
        logic [7:0] dst_b;
        logic [7:0] dst_a;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] out_r;
        logic [7:0] out_g;
        logic [7:0] out_b;
        logic [7:0] out_a;
    } t_pix_out;

endpackage

>>> rtl/aob_div_lane.sv
// ----------------------------------------------------------------------------
// aob_div_lane
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module aob_div_lane (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [aob_pkg::NUM_W-1:0] i_num,
    input  logic [aob_pkg::D_W-1:0]   i_den,
    output logic [aob_pkg::Q_W-1:0]   o_quo
);
    import aob_pkg::*;

    logic [NUM_W-1:0] r_rem [Q_W];
    logic [D_W-1:0]   r_den [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [D_W-1:0]   den_in;
        logic [Q_W-1:0]   quo_in;
        logic [NUM_W:0]   sub;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign quo_in = r_quo[k-1];
        end

        assign sub = (NUM_W + 1)'(den_in) << (Q_W - 1 - k);
        assign ge  = {1'b0, rem_in} >= sub;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? NUM_W'({1'b0, rem_in} - sub) : rem_in;
                r_den[k] <= den_in;
                r_quo[k] <= ge ? (quo_in | (Q_W'(1) << (Q_W - 1 - k))) : quo_in;
            end
        end
    end

    assign o_quo = r_quo[Q_W-1];

endmodule

>>> rtl/alpha_over_blend_opacity_unit.sv
// ----------------------------------------------------------------------------
// alpha_over_blend_opacity_unit
// Straight-alpha source-over blend of one RGBA8 pixel pair per clock, with
// the source alpha scaled by a layer opacity register.
//
// Input channel i_valid/o_stall carries a source and destination pixel;
// output channel o_valid/i_stall returns the blended pixel. A transaction
// takes place on a rising edge with valid high and stall low.
// Opacity (Q1.16, reset 1.0) is written on the config channel, which is
// always ready; write it only while the pipeline is empty.
// Sixteen register stages: six arithmetic stages, nine divider stages (one
// quotient bit each) and the output register. Throughput is one pixel per
// clock while the output is not stalled.
// Reset is synchronous and active low; it empties the pipeline and sets
// opacity to 1.0.
// A stall on a valid output freezes every stage and stalls the input; nothing
// is lost or repeated.
// ----------------------------------------------------------------------------
module alpha_over_blend_opacity_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  aob_pkg::t_pix_in         i_pix,
    output logic                     o_valid,
    input  logic                     i_stall,
    output aob_pkg::t_pix_out        o_pix,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [aob_pkg::OP_W-1:0] i_cfg_data
);
    import aob_pkg::*;

    logic adv;

    logic [OP_W-1:0] r_opacity;
    logic [OP_W-1:0] op;

    // stage 1
    logic            r1_v;
    t_pix_in         r1_px;
    logic [Y_W-1:0]  r1_sop;
    logic [Y_W-1:0]  r1_dop;
    logic            r1_opc;
    // stage 2
    logic            r2_v;
    t_pix_in         r2_px;
    logic [Y_W-1:0]  r2_ys;
    logic [Y_W-1:0]  r2_yd;
    logic [Y_W-1:0]  r2_qs;
    logic [Y_W-1:0]  r2_qd;
    logic            r2_opc;
    // stage 3
    logic            r3_v;
    t_pix_in         r3_px;
    logic [OP_W-1:0] r3_srca;
    logic [OP_W-1:0] r3_dsta;
    logic            r3_zero;
    logic            r3_copy;
    // stage 4
    logic              r4_v;
    t_pix_in           r4_px;
    logic [2*OP_W-1:0] r4_p;
    logic [OP_W-1:0]   r4_srca;
    logic              r4_zero;
    logic              r4_copy;
    // stage 5
    logic              r5_v;
    t_pix_in           r5_px;
    logic [OP_W-1:0]   r5_srca;
    logic [OP_W-1:0]   r5_dwt;
    logic [OUTA_W-1:0] r5_outa;
    logic              r5_zero;
    logic              r5_copy;
    // stage 6
    logic              r6_v;
    t_pix_in           r6_px;
    logic [NUM_W-1:0]  r6_n [3];
    logic [D_W-1:0]    r6_d;
    logic [7:0]        r6_oa;
    logic              r6_zero;
    logic              r6_copy;
    // side pipe alongside the divider
    logic              r_sv    [DIV_LAT];
    t_pix_in           r_spx   [DIV_LAT];
    logic [7:0]        r_soa   [DIV_LAT];
    logic              r_szero [DIV_LAT];
    logic              r_scopy [DIV_LAT];
    logic [Q_W-1:0]    quo [3];

    logic               r_ov;
    t_pix_out           r_opix;

    logic [Y_W+RECIP_SH-1:0] ms, md;
    logic [Y_W-1:0]          ys, yd, rs, rd, qs, qd;
    logic [OP_W-1:0]         srca_n, dsta_n;
    logic [OP_W+FRAC_BITS-1:0] p_rnd;
    logic [OP_W-1:0]           dwt_n;
    logic [NUM_W-1:0]          num [3];
    logic [OUTA_W+8:0]         oa_full;
    logic [OUTA_W+8-FRAC_BITS:0] oa_sh;
    t_pix_out                  res;
    t_pix_in                   lpx;

    assign adv         = !(r_ov && i_stall);
    assign o_stall     = !adv;
    assign o_valid     = r_ov;
    assign o_pix       = r_opix;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity <= ONE;
        end else if (i_cfg_valid) begin
            r_opacity <= i_cfg_data;
        end
    end

    assign op = (r_opacity > ONE) ? ONE : r_opacity;

    // stage 1: opacity product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (adv) begin
            r1_v <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_px  <= i_pix;
            r1_sop <= Y_W'(i_pix.src_a) * Y_W'(op);
            r1_dop <= Y_W'({i_pix.dst_a, {FRAC_BITS{1'b0}}});
            r1_opc <= op >= COPY_THRESH;
        end
    end

    // stage 2: reciprocal estimate of /255
    assign ys = r1_sop + Y_W'(127);
    assign yd = r1_dop + Y_W'(127);
    assign ms = (Y_W + RECIP_SH)'(ys) * (Y_W + RECIP_SH)'(RECIP_255);
    assign md = (Y_W + RECIP_SH)'(yd) * (Y_W + RECIP_SH)'(RECIP_255);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (adv) begin
            r2_v <= r1_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r2_px  <= r1_px;
            r2_ys  <= ys;
            r2_yd  <= yd;
            r2_qs  <= ms[Y_W+RECIP_SH-1:RECIP_SH];
            r2_qd  <= md[Y_W+RECIP_SH-1:RECIP_SH];
            r2_opc <= r1_opc;
        end
    end

    // stage 3: correction, clamp and special cases
    assign rs = r2_ys - ((r2_qs << 8) - r2_qs);
    assign rd = r2_yd - ((r2_qd << 8) - r2_qd);
    assign qs = r2_qs + Y_W'(rs >= Y_W'(255));
    assign qd = r2_qd + Y_W'(rd >= Y_W'(255));
    assign srca_n = (qs > Y_W'(ONE)) ? ONE : qs[OP_W-1:0];
    assign dsta_n = (qd > Y_W'(ONE)) ? ONE : qd[OP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (adv) begin
            r3_v <= r2_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r3_px   <= r2_px;
            r3_srca <= srca_n;
            r3_dsta <= dsta_n;
            r3_zero <= srca_n == '0;
            r3_copy <= (r2_px.src_a == 8'd255) && r2_opc && (r2_px.dst_a == 8'd0);
        end
    end

    // stage 4: destination weight product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (adv) begin
            r4_v <= r3_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r4_px   <= r3_px;
            r4_p    <= r3_dsta * (ONE - r3_srca);
            r4_srca <= r3_srca;
            r4_zero <= r3_zero;
            r4_copy <= r3_copy;
        end
    end

    // stage 5: round weight, output alpha fraction
    assign p_rnd = (OP_W + FRAC_BITS)'(r4_p) + (OP_W + FRAC_BITS)'(ONE >> 1);
    assign dwt_n = p_rnd[OP_W+FRAC_BITS-1:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (adv) begin
            r5_v <= r4_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r5_px   <= r4_px;
            r5_srca <= r4_srca;
            r5_dwt  <= dwt_n;
            r5_outa <= OUTA_W'(r4_srca) + OUTA_W'(dwt_n);
            r5_zero <= r4_zero;
            r5_copy <= r4_copy;
        end
    end

    // stage 6: channel numerators and alpha
    assign num[0] = NUM_W'(r5_px.src_r) * NUM_W'(r5_srca)
                  + NUM_W'(r5_px.dst_r) * NUM_W'(r5_dwt);
    assign num[1] = NUM_W'(r5_px.src_g) * NUM_W'(r5_srca)
                  + NUM_W'(r5_px.dst_g) * NUM_W'(r5_dwt);
    assign num[2] = NUM_W'(r5_px.src_b) * NUM_W'(r5_srca)
                  + NUM_W'(r5_px.dst_b) * NUM_W'(r5_dwt);
    assign oa_full = (OUTA_W + 9)'(r5_outa) * (OUTA_W + 9)'(255)
                   + (OUTA_W + 9)'(ONE >> 1);
    assign oa_sh   = oa_full[OUTA_W+8:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (adv) begin
            r6_v <= r5_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r6_px   <= r5_px;
            for (int c = 0; c < 3; c++) begin
                r6_n[c] <= (num[c] << 1) + NUM_W'(r5_outa);
            end
            r6_d    <= D_W'(r5_outa) << 1;
            r6_oa   <= (oa_sh > (OUTA_W + 9 - FRAC_BITS)'(255)) ? 8'd255 : oa_sh[7:0];
            r6_zero <= r5_zero;
            r6_copy <= r5_copy;
        end
    end

    // dividers
    for (genvar c = 0; c < 3; c++) begin : g_lane
        aob_div_lane u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num (r6_n[c]),
            .i_den (r6_d),
            .o_quo (quo[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_sv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_sv[0] <= r6_v;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_spx[0]   <= r6_px;
            r_soa[0]   <= r6_oa;
            r_szero[0] <= r6_zero;
            r_scopy[0] <= r6_copy;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_spx[k]   <= r_spx[k-1];
                r_soa[k]   <= r_soa[k-1];
                r_szero[k] <= r_szero[k-1];
                r_scopy[k] <= r_scopy[k-1];
            end
        end
    end

    // output select
    assign lpx = r_spx[DIV_LAT-1];

    always_comb begin
        priority if (r_szero[DIV_LAT-1]) begin
            res = '{lpx.dst_r, lpx.dst_g, lpx.dst_b, lpx.dst_a};
        end else if (r_scopy[DIV_LAT-1]) begin
            res = '{lpx.src_r, lpx.src_g, lpx.src_b, lpx.src_a};
        end else begin
            res.out_r = (quo[0] > Q_W'(255)) ? 8'd255 : quo[0][7:0];
            res.out_g = (quo[1] > Q_W'(255)) ? 8'd255 : quo[1][7:0];
            res.out_b = (quo[2] > Q_W'(255)) ? 8'd255 : quo[2][7:0];
            res.out_a = r_soa[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_sv[DIV_LAT-1];
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_opix <= res;
        end
    end

endmodule

>>> bench/aob_checker.sv
// ----------------------------------------------------------------------------
// aob_checker
// Watches the pixel and opacity channels of the blend unit, predicts each
// blended pixel from the current opacity and compares it with the output.
// ----------------------------------------------------------------------------
module aob_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  logic                     i_in_stall,
    input  aob_pkg::t_pix_in         i_pix,
    input  logic                     i_out_valid,
    input  logic                     i_out_stall,
    input  aob_pkg::t_pix_out        i_res,
    input  logic                     i_cfg_valid,
    input  logic                     i_cfg_ready,
    input  logic [aob_pkg::OP_W-1:0] i_cfg_data,
    output int                       o_fail_cnt,
    output int                       o_pending,
    output int                       o_blend_cnt,
    output int                       o_pass_cnt,
    output int                       o_copy_cnt
);
    import aob_pkg::*;

    logic [OP_W-1:0] opacity_q;
    t_pix_out        exp_mem [256];
    int              wr_cnt;
    int              rd_cnt;

    function automatic logic [63:0] rnd_div(logic [63:0] n, logic [63:0] d);
        if (d == 0) return 0;
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic logic [7:0] clip8(logic [63:0] v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic t_pix_out blend_pixel(t_pix_in p, logic [OP_W-1:0] opac);
        logic [63:0] one_v, op_v, sa, da, dw, oa;
        t_pix_out    r;
        one_v = 64'd1 << FRAC_BITS;
        op_v  = (opac > one_v) ? one_v : 64'(opac);
        sa    = rnd_div(64'(p.src_a) * op_v, 255);
        if (sa > one_v) sa = one_v;
        if (sa == 0) begin
            r = '{p.dst_r, p.dst_g, p.dst_b, p.dst_a};
            o_pass_cnt++;
        end else if (p.src_a == 8'd255 && op_v >= 64'(COPY_THRESH) && p.dst_a == 0) begin
            r = '{p.src_r, p.src_g, p.src_b, p.src_a};
            o_copy_cnt++;
        end else begin
            da = rnd_div(64'(p.dst_a) * one_v, 255);
            dw = rnd_div(da * (one_v - sa), one_v);
            oa = sa + dw;
            r.out_r = clip8(rnd_div(p.src_r * sa + p.dst_r * dw, oa));
            r.out_g = clip8(rnd_div(p.src_g * sa + p.dst_g * dw, oa));
            r.out_b = clip8(rnd_div(p.src_b * sa + p.dst_b * dw, oa));
            r.out_a = clip8(rnd_div(oa * 255, one_v));
            o_blend_cnt++;
        end
        return r;
    endfunction

    initial begin
        o_fail_cnt = 0;
        o_blend_cnt = 0;
        o_pass_cnt = 0;
        o_copy_cnt = 0;
        wr_cnt = 0;
        rd_cnt = 0;
    end

    assign o_pending = wr_cnt - rd_cnt;

    always @(posedge i_clk) begin
        t_pix_out exp_px;
        if (!i_rst_n) begin
            opacity_q <= ONE;
        end else begin
            if (i_cfg_valid && i_cfg_ready) opacity_q <= i_cfg_data;
            if (i_valid && !i_in_stall) begin
                exp_mem[8'(wr_cnt)] <= blend_pixel(i_pix, opacity_q);
                wr_cnt <= wr_cnt + 1;
            end
            if (i_out_valid && !i_out_stall) begin
                if (rd_cnt == wr_cnt) begin
                    $error("unexpected output transaction %h", i_res);
                    o_fail_cnt++;
                end else begin
                    exp_px = exp_mem[8'(rd_cnt)];
                    rd_cnt <= rd_cnt + 1;
                    if (i_res.out_r !== exp_px.out_r) begin
                        $error("out_r: expected %0d, got %0d", exp_px.out_r, i_res.out_r);
                        o_fail_cnt++;
                    end
                    if (i_res.out_g !== exp_px.out_g) begin
                        $error("out_g: expected %0d, got %0d", exp_px.out_g, i_res.out_g);
                        o_fail_cnt++;
                    end
                    if (i_res.out_b !== exp_px.out_b) begin
                        $error("out_b: expected %0d, got %0d", exp_px.out_b, i_res.out_b);
                        o_fail_cnt++;
                    end
                    if (i_res.out_a !== exp_px.out_a) begin
                        $error("out_a: expected %0d, got %0d", exp_px.out_a, i_res.out_a);
                        o_fail_cnt++;
                    end
                end
            end
        end
    end

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the alpha-over opacity blend unit: directed corner pixels,
// then random pixel pairs over several opacity settings, with bursty input,
// patterned output stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb;
    import aob_pkg::*;

    localparam int LIMIT       = 200000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_stall;
    t_pix_in         i_pix;
    logic            o_valid;
    logic            i_stall;
    t_pix_out        o_pix;
    logic            i_cfg_valid;
    logic            o_cfg_ready;
    logic [OP_W-1:0] i_cfg_data;

    int  fail_cnt, pending, blend_cnt, pass_cnt, copy_cnt;
    int  cycle_cnt;
    int  item_cnt;
    bit  hold_off_req;
    bit  no_stall;

    alpha_over_blend_opacity_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_pix      (i_pix),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_pix      (o_pix),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    aob_checker chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_in_stall (o_stall),
        .i_pix      (i_pix),
        .i_out_valid(o_valid),
        .i_out_stall(i_stall),
        .i_res      (o_pix),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending),
        .o_blend_cnt(blend_cnt),
        .o_pass_cnt (pass_cnt),
        .o_copy_cnt (copy_cnt)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge i_clk);
            cycle_cnt++;
            if (cycle_cnt >= LIMIT) begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("** alpha_over_blend_opacity_unit: FAILED **");
                $finish;
            end
        end
    end

    // receiver: patterned stalls, plus a long hold-off on request
    initial begin
        int mode, n;
        i_stall <= 1'b0;
        forever begin
            if (hold_off_req) begin
                i_stall <= 1'b1;
                repeat (60) @(posedge i_clk);
                hold_off_req = 0;
            end
            mode = $urandom_range(0, 3);
            n = $urandom_range(1, 20);
            repeat (n) begin
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0) && !no_stall;
                    2: i_stall <= ($urandom_range(0, 1) == 0) && !no_stall;
                    default: i_stall <= ($urandom_range(0, 4) != 0) && !no_stall;
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_pixel(t_pix_in p);
        i_pix   <= p;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        item_cnt++;
    endtask

    task automatic drop_valid();
        i_valid <= 1'b0;
        i_pix   <= t_pix_in'($urandom());
    endtask

    task automatic drain();
        drop_valid();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DIV_LAT + 10) @(posedge i_clk);
    endtask

    task automatic write_opacity(logic [OP_W-1:0] v);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_pix_in rand_pixel();
        t_pix_in p;
        p = t_pix_in'({$urandom(), $urandom()});
        case ($urandom_range(0, 7))
            0: p.src_a = 8'd0;
            1: p.src_a = 8'd255;
            2: p.dst_a = 8'd0;
            3: begin p.src_a = 8'd255; p.dst_a = 8'd0; end
            4: p.dst_a = 8'd255;
            default: ;
        endcase
        return p;
    endfunction

    task automatic random_burst(int count);
        int gap;
        repeat (count) begin
            if ($urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 6);
                drop_valid();
                repeat (gap) @(posedge i_clk);
            end
            send_pixel(rand_pixel());
        end
    endtask

    logic [OP_W-1:0] opac_set[10];

    initial begin
        item_cnt = 0;
        hold_off_req = 0;
        no_stall = 0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_pix       <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset opacity
        send_pixel('{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        send_pixel('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
        send_pixel('{8'd10, 8'd20, 8'd30, 8'd255, 8'd1, 8'd2, 8'd3, 8'd0});
        send_pixel('{8'd10, 8'd20, 8'd30, 8'd0, 8'd40, 8'd50, 8'd60, 8'd70});
        send_pixel('{8'hff, 8'h00, 8'haa, 8'd1, 8'h00, 8'hff, 8'h55, 8'd0});
        send_pixel('{8'h00, 8'hff, 8'h55, 8'd128, 8'hff, 8'h00, 8'haa, 8'd128});
        send_pixel('{8'h55, 8'haa, 8'h0f, 8'd255, 8'haa, 8'h55, 8'hf0, 8'd255});
        send_pixel('{8'd1, 8'd254, 8'd128, 8'd254, 8'd254, 8'd1, 8'd127, 8'd1});
        drain();
        write_opacity(17'd0);
        send_pixel('{8'd9, 8'd8, 8'd7, 8'd255, 8'd6, 8'd5, 8'd4, 8'd3});
        drain();
        write_opacity(17'd65471);
        send_pixel('{8'd9, 8'd8, 8'd7, 8'd255, 8'd6, 8'd5, 8'd4, 8'd0});
        drain();
        write_opacity(17'd65470);
        send_pixel('{8'd9, 8'd8, 8'd7, 8'd255, 8'd6, 8'd5, 8'd4, 8'd0});
        drain();
        write_opacity(17'h1ffff);
        send_pixel('{8'd9, 8'd8, 8'd7, 8'd255, 8'd6, 8'd5, 8'd4, 8'd0});
        send_pixel('{8'd90, 8'd80, 8'd70, 8'd100, 8'd60, 8'd50, 8'd40, 8'd200});
        drain();
        write_opacity(17'd1);
        send_pixel('{8'd90, 8'd80, 8'd70, 8'd255, 8'd60, 8'd50, 8'd40, 8'd200});
        send_pixel('{8'd90, 8'd80, 8'd70, 8'd127, 8'd60, 8'd50, 8'd40, 8'd0});
        drain();

        // random phases across opacity settings
        opac_set = '{17'd65536, 17'd0, 17'h1ffff, 17'd65471, 17'd1, 17'd32768,
                     17'd65535, 17'd256, 17'd65537, 17'd40000};
        foreach (opac_set[k]) begin
            write_opacity((k == 9) ? OP_W'($urandom()) : opac_set[k]);
            if (k == 3) begin
                // long output hold-off while input keeps coming
                hold_off_req = 1;
                repeat (30) send_pixel(rand_pixel());
            end
            if (k == 5) no_stall = 1;
            random_burst(36);
            no_stall = 0;
            drain();
        end

        $display("covered %0d pixels over %0d opacity settings", item_cnt, 16);
        $display("blended %0d, passed through %0d, copied %0d",
                 blend_cnt, pass_cnt, copy_cnt);
        if (fail_cnt == 0) begin
            $display("** alpha_over_blend_opacity_unit: PASSED **");
        end else begin
            $display("** alpha_over_blend_opacity_unit: FAILED **");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/aob_pkg.sv
rtl/aob_div_lane.sv
rtl/alpha_over_blend_opacity_unit.sv
bench/aob_checker.sv
bench/tb.sv
